// ===== sv/gpe_pkg.sv =====
// gait phase estimator package: field widths, reset values, register indexes,
// controller states and the command/status structs
// no dependencies
`default_nettype none

package gpe_pkg;

    localparam int ADC_W      = 10;
    localparam int STATUS_W   = 8;
    localparam int HOLD_W     = 8;
    localparam int TICK_W     = 12;
    localparam int PCT_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int DIVD_W     = 27;
    localparam int NSIDE      = 2;

    localparam logic [PCT_W-1:0]  PCT_FULL = 15'd25600;
    localparam logic [HOLD_W-1:0] HOLD_MAX = 8'd255;

    localparam logic [ADC_W-1:0]  THRESH_RST  = 10'd512;
    localparam logic [HOLD_W-1:0] DEBOUNCE_RST = 8'd10;
    localparam logic [TICK_W-1:0] MIN_STEP_RST = 12'd40;
    localparam logic [TICK_W-1:0] TIMEOUT_RST  = 12'd600;
    localparam logic [TICK_W-1:0] INIT_STEP_RST = 12'd200;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP = 3'd4;

    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVIDE,
        ST_PUBLISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic prep;
        logic finish;
        logic publish;
        logic side;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/gait_phase_estimator.sv =====
// gait phase estimator top level: controller, datapath, checks
// depends on gpe_pkg, gpe_ctrl, gpe_datapath
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    eight 10-bit pressure samples
// output    out        o_out_valid / i_out_stall  status, contacts, percents, averages
// config    in         i_cfg_wr_en                i_cfg_index, i_cfg_data
//
// after acceptance, each side whose percent is needed goes through the shared
// 27-bit shift-subtract divider, and each side that closes a step updates its
// ring average by reciprocal multiply
// the next request can be taken in the cycle after the result is loaded
// synchronous active-low reset; no clearing pass
// a stalled result holds the block before the load of the next result only
`default_nettype none

module gait_phase_estimator
    import gpe_pkg::*;
#(
    parameter int HISTORY = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [ADC_W-1:0]      i_toe_left,
    input  wire logic [ADC_W-1:0]      i_heel_left,
    input  wire logic [ADC_W-1:0]      i_mid_a_left,
    input  wire logic [ADC_W-1:0]      i_mid_b_left,
    input  wire logic [ADC_W-1:0]      i_toe_right,
    input  wire logic [ADC_W-1:0]      i_heel_right,
    input  wire logic [ADC_W-1:0]      i_mid_a_right,
    input  wire logic [ADC_W-1:0]      i_mid_b_right,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [STATUS_W-1:0]        o_sensor_status,
    output logic                       o_contact_left,
    output logic                       o_contact_right,
    output logic [PCT_W-1:0]           o_percent_left,
    output logic [PCT_W-1:0]           o_percent_right,
    output logic [TICK_W-1:0]          o_avg_step_left,
    output logic [TICK_W-1:0]          o_avg_step_right,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    gpe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gpe_datapath #(
        .HISTORY (HISTORY)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_toe_left        (i_toe_left),
        .i_heel_left       (i_heel_left),
        .i_mid_a_left      (i_mid_a_left),
        .i_mid_b_left      (i_mid_b_left),
        .i_toe_right       (i_toe_right),
        .i_heel_right      (i_heel_right),
        .i_mid_a_right     (i_mid_a_right),
        .i_mid_b_right     (i_mid_b_right),
        .o_sensor_status   (o_sensor_status),
        .o_contact_left    (o_contact_left),
        .o_contact_right   (o_contact_right),
        .o_percent_left    (o_percent_left),
        .o_percent_right   (o_percent_right),
        .o_avg_step_left   (o_avg_step_left),
        .o_avg_step_right  (o_avg_step_right)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.publish |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over an unaccepted one");

    a_div_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.prep && sts.need_div) |=> (sts.div_busy || sts.div_done))
        else $error("divide did not start");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while previous one in flight");
`endif

endmodule

`default_nettype wire

// ===== sv/gpe_div.sv =====
// gait phase estimator divider: restoring, one quotient bit per cycle
// depends on gpe_pkg
`default_nettype none

module gpe_div
    import gpe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVD_W-1:0] i_dividend,
    input  wire logic [TICK_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [DIVD_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DIVD_W-1:0] r_quo;
    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] r_dvs;

    logic [TICK_W:0]   trial;
    logic [TICK_W:0]   diff;
    logic              fits;
    logic [TICK_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = trial >= {1'b0, r_dvs};
        n_rem = fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DIVD_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIVD_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ===== sv/gpe_datapath.sv =====
// gait phase estimator datapath: config registers, contact compare, debounce,
// step history rings, averages and percents, output registers
// depends on gpe_pkg and gpe_div
`default_nettype none

module gpe_datapath
    import gpe_pkg::*;
#(
    parameter int HISTORY = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [ADC_W-1:0]      i_toe_left,
    input  wire logic [ADC_W-1:0]      i_heel_left,
    input  wire logic [ADC_W-1:0]      i_mid_a_left,
    input  wire logic [ADC_W-1:0]      i_mid_b_left,
    input  wire logic [ADC_W-1:0]      i_toe_right,
    input  wire logic [ADC_W-1:0]      i_heel_right,
    input  wire logic [ADC_W-1:0]      i_mid_a_right,
    input  wire logic [ADC_W-1:0]      i_mid_b_right,
    output logic [STATUS_W-1:0]        o_sensor_status,
    output logic                       o_contact_left,
    output logic                       o_contact_right,
    output logic [PCT_W-1:0]           o_percent_left,
    output logic [PCT_W-1:0]           o_percent_right,
    output logic [TICK_W-1:0]          o_avg_step_left,
    output logic [TICK_W-1:0]          o_avg_step_right
);

    localparam int SLOT_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int SUM_W  = TICK_W + $clog2(HISTORY);

    // ring average by reciprocal multiply, exact for depths up to 8
    localparam int AVG_SHIFT = SUM_W + 3;
    localparam int PROD_W    = AVG_SHIFT + TICK_W;
    localparam longint unsigned AVG_RECIP =
        ((64'd1 << AVG_SHIFT) + 64'(HISTORY) - 64'd1) / 64'(HISTORY);

    logic [ADC_W-1:0]  r_threshold;
    logic [HOLD_W-1:0] r_debounce;
    logic [TICK_W-1:0] r_min_step;
    logic [TICK_W-1:0] r_timeout;

    logic              r_raw_prev [NSIDE];
    logic              r_deb      [NSIDE];
    logic [HOLD_W-1:0] r_hold     [NSIDE];
    logic [TICK_W-1:0] r_ticks    [NSIDE];
    logic [TICK_W-1:0] r_hist     [NSIDE][HISTORY];
    logic [SLOT_W-1:0] r_slot     [NSIDE];
    logic [SUM_W-1:0]  r_sum      [NSIDE];
    logic [TICK_W-1:0] r_avg      [NSIDE];

    logic [STATUS_W-1:0] r_status;
    logic [PCT_W-1:0]    r_pct [NSIDE];
    logic                r_div_avg;
    logic                r_avg_pend;

    logic [STATUS_W-1:0] r_o_status;
    logic                r_o_contact_l;
    logic                r_o_contact_r;
    logic [PCT_W-1:0]    r_o_pct_l;
    logic [PCT_W-1:0]    r_o_pct_r;
    logic [TICK_W-1:0]   r_o_avg_l;
    logic [TICK_W-1:0]   r_o_avg_r;

    logic                sel;
    logic [STATUS_W-1:0] contact_bits;
    logic                raw;
    logic                take_change;
    logic                n_deb;
    logic [HOLD_W-1:0]   n_hold;
    logic                step_end;
    logic [TICK_W-1:0]   step_len;
    logic [SLOT_W-1:0]   cur_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic [SUM_W-1:0]    n_sum;
    logic                in_window;
    logic                avg_zero;
    logic                need_div;
    logic                div_start;
    logic [DIVD_W-1:0]   div_dividend;
    logic [TICK_W-1:0]   div_divisor;
    logic                div_busy;
    logic                div_done;
    logic [DIVD_W-1:0]   quotient;
    logic [PCT_W-1:0]    pct_q;
    logic [PROD_W-1:0]   avg_prod;
    logic [TICK_W-1:0]   avg_q;

    always_comb begin
        contact_bits[0] = i_toe_left    >= r_threshold;
        contact_bits[1] = i_heel_left   >= r_threshold;
        contact_bits[2] = i_mid_a_left  >= r_threshold;
        contact_bits[3] = i_mid_b_left  >= r_threshold;
        contact_bits[4] = i_toe_right   >= r_threshold;
        contact_bits[5] = i_heel_right  >= r_threshold;
        contact_bits[6] = i_mid_a_right >= r_threshold;
        contact_bits[7] = i_mid_b_right >= r_threshold;
    end

    always_comb begin
        sel         = i_cmd.side;
        raw         = (sel == SIDE_RIGHT) ? r_status[5] : r_status[1];
        take_change = (raw != r_raw_prev[sel]) && (r_hold[sel] > r_debounce);
        n_deb       = take_change ? raw : r_deb[sel];
        if (take_change) begin
            n_hold = '0;
        end else if (r_hold[sel] != HOLD_MAX) begin
            n_hold = r_hold[sel] + 1'b1;
        end else begin
            n_hold = r_hold[sel];
        end
        step_end  = r_deb[sel] && !n_deb;
        step_len  = (r_ticks[sel] < r_min_step) ? r_min_step : r_ticks[sel];
        cur_slot  = r_slot[sel];
        n_slot    = (cur_slot == SLOT_W'(HISTORY - 1)) ? '0 : cur_slot + 1'b1;
        n_sum     = r_sum[sel] - SUM_W'(r_hist[sel][cur_slot]) + SUM_W'(step_len);
        in_window = r_ticks[sel] < r_timeout;
        avg_zero  = (r_avg[sel] == '0);
        need_div  = step_end || (in_window && !avg_zero);
        div_start = i_cmd.prep && need_div && !step_end;
        div_dividend = DIVD_W'(r_ticks[sel]) * DIVD_W'(PCT_FULL);
        div_divisor  = r_avg[sel];
        pct_q = (quotient > DIVD_W'(PCT_FULL)) ? PCT_FULL : quotient[PCT_W-1:0];
        avg_prod = PROD_W'(r_sum[sel]) * PROD_W'(AVG_RECIP);
        avg_q    = avg_prod[PROD_W-1 -: TICK_W];
    end

    gpe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RST;
            r_debounce  <= DEBOUNCE_RST;
            r_min_step  <= MIN_STEP_RST;
            r_timeout   <= TIMEOUT_RST;
            r_avg_pend  <= 1'b0;
            for (int s = 0; s < NSIDE; s++) begin
                r_raw_prev[s] <= 1'b0;
                r_deb[s]      <= 1'b0;
                r_hold[s]     <= '0;
                r_ticks[s]    <= '0;
                r_slot[s]     <= '0;
                r_sum[s]      <= SUM_W'(INIT_STEP_RST) * SUM_W'(HISTORY);
                r_avg[s]      <= '0;
                for (int h = 0; h < HISTORY; h++) begin
                    r_hist[s][h] <= INIT_STEP_RST;
                end
            end
        end else begin
            r_avg_pend <= i_cmd.prep && step_end;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_THRESHOLD: r_threshold <= i_cfg_data[ADC_W-1:0];
                    CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[HOLD_W-1:0];
                    CFG_MIN_STEP:  r_min_step  <= i_cfg_data[TICK_W-1:0];
                    CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TICK_W-1:0];
                    CFG_INIT_STEP: begin
                        for (int s = 0; s < NSIDE; s++) begin
                            r_slot[s] <= '0;
                            r_sum[s]  <= SUM_W'(i_cfg_data[TICK_W-1:0]) * SUM_W'(HISTORY);
                            for (int h = 0; h < HISTORY; h++) begin
                                r_hist[s][h] <= i_cfg_data[TICK_W-1:0];
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.prep) begin
                r_raw_prev[sel] <= raw;
                r_deb[sel]      <= n_deb;
                r_hold[sel]     <= n_hold;
                if (step_end) begin
                    r_sum[sel]            <= n_sum;
                    r_hist[sel][cur_slot] <= step_len;
                    r_slot[sel]           <= n_slot;
                    r_ticks[sel]          <= '0;
                end else if (in_window) begin
                    r_ticks[sel] <= r_ticks[sel] + 1'b1;
                end
            end
            if (i_cmd.finish && r_div_avg) begin
                r_avg[sel] <= avg_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_status <= contact_bits;
        end
        if (i_cmd.prep) begin
            r_div_avg <= step_end;
            if (step_end || !in_window) begin
                r_pct[sel] <= '0;
            end else if (avg_zero) begin
                r_pct[sel] <= (r_ticks[sel] != '0) ? PCT_FULL : '0;
            end
        end
        if (i_cmd.finish && !r_div_avg) begin
            r_pct[sel] <= pct_q;
        end
        if (i_cmd.publish) begin
            r_o_status    <= r_status;
            r_o_contact_l <= r_deb[0];
            r_o_contact_r <= r_deb[1];
            r_o_pct_l     <= r_pct[0];
            r_o_pct_r     <= r_pct[1];
            r_o_avg_l     <= r_avg[0];
            r_o_avg_r     <= r_avg[1];
        end
    end

    always_comb begin
        o_sts.need_div = need_div;
        o_sts.div_busy = div_busy;
        o_sts.div_done = div_done || r_avg_pend;
    end

    assign o_sensor_status   = r_o_status;
    assign o_contact_left    = r_o_contact_l;
    assign o_contact_right   = r_o_contact_r;
    assign o_percent_left    = r_o_pct_l;
    assign o_percent_right   = r_o_pct_r;
    assign o_avg_step_left   = r_o_avg_l;
    assign o_avg_step_right  = r_o_avg_r;

endmodule

`default_nettype wire

// ===== sv/gpe_ctrl.sv =====
// gait phase estimator controller: walks left then right side through
// update and divide, then hands the result to the output register
// depends on gpe_pkg
`default_nettype none

module gpe_ctrl
    import gpe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_side;
    logic   n_side;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PREP;
                    n_side  = SIDE_LEFT;
                end
            end
            ST_PREP: begin
                if (i_sts.need_div) begin
                    n_state = ST_DIVIDE;
                end else if (r_side == SIDE_RIGHT) begin
                    n_state = ST_PUBLISH;
                end else begin
                    n_side = SIDE_RIGHT;
                end
            end
            ST_DIVIDE: begin
                if (i_sts.div_done) begin
                    if (r_side == SIDE_RIGHT) begin
                        n_state = ST_PUBLISH;
                    end else begin
                        n_state = ST_PREP;
                        n_side  = SIDE_RIGHT;
                    end
                end
            end
            ST_PUBLISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.capture = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.prep    = (r_state == ST_PREP);
        o_cmd.finish  = (r_state == ST_DIVIDE) && i_sts.div_done;
        o_cmd.publish = (r_state == ST_PUBLISH) && out_free;
        o_cmd.side    = r_side;
        o_in_stall    = (r_state != ST_IDLE);
        if (o_cmd.publish) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_side      <= SIDE_LEFT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_side      <= n_side;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== tb/gpe_checker.sv =====
// gait phase estimator checker: follows the sample, result and register ports,
// predicts every result from its own copy of the state and compares it field by field
// depends on gpe_pkg
module gpe_checker
    import gpe_pkg::*;
#(
    parameter int HISTORY = 3
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic [ADC_W-1:0]      i_toe_left,
    input  wire logic [ADC_W-1:0]      i_heel_left,
    input  wire logic [ADC_W-1:0]      i_mid_a_left,
    input  wire logic [ADC_W-1:0]      i_mid_b_left,
    input  wire logic [ADC_W-1:0]      i_toe_right,
    input  wire logic [ADC_W-1:0]      i_heel_right,
    input  wire logic [ADC_W-1:0]      i_mid_a_right,
    input  wire logic [ADC_W-1:0]      i_mid_b_right,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [STATUS_W-1:0]   i_sensor_status,
    input  wire logic                  i_contact_left,
    input  wire logic                  i_contact_right,
    input  wire logic [PCT_W-1:0]      i_percent_left,
    input  wire logic [PCT_W-1:0]      i_percent_right,
    input  wire logic [TICK_W-1:0]     i_avg_step_left,
    input  wire logic [TICK_W-1:0]     i_avg_step_right,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NPAD           = 8;
    localparam int          HEEL_BIT_LEFT  = 1;
    localparam int          HEEL_BIT_RIGHT = 5;
    localparam int unsigned FULL           = PCT_FULL;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                contact_left;
        logic                contact_right;
        logic [PCT_W-1:0]    percent_left;
        logic [PCT_W-1:0]    percent_right;
        logic [TICK_W-1:0]   avg_left;
        logic [TICK_W-1:0]   avg_right;
    } t_gait_sample;

    t_gait_sample      gait_due [$];
    logic [ADC_W-1:0]  thresh;
    logic [HOLD_W-1:0] debounce;
    logic [TICK_W-1:0] min_step;
    logic [TICK_W-1:0] timeout;
    logic [TICK_W-1:0] init_step;
    bit                heel_prev [NSIDE];
    bit                contact   [NSIDE];
    int unsigned       hold      [NSIDE];
    int unsigned       ticks     [NSIDE];
    int unsigned       slot      [NSIDE];
    int unsigned       ring_sum  [NSIDE];
    int unsigned       avg_step  [NSIDE];
    int unsigned       ring      [NSIDE][HISTORY];
    int                fails = 0;

    assign o_fail_count = fails;

    task automatic refill_rings();
        for (int s = 0; s < NSIDE; s++) begin
            for (int k = 0; k < HISTORY; k++) ring[s][k] = init_step;
            ring_sum[s] = init_step * HISTORY;
            slot[s] = 0;
        end
    endtask

    // debounce one heel, close a step on a falling contact, return the gait percent
    function automatic int unsigned advance_side(input int s, input bit heel);
        bit          was_down;
        int unsigned pct;
        int unsigned len;
        was_down = contact[s];
        pct = 0;
        if (heel != heel_prev[s] && hold[s] > debounce) begin
            contact[s] = heel;
            hold[s] = 0;
        end else if (hold[s] < HOLD_MAX) begin
            hold[s]++;
        end
        heel_prev[s] = heel;
        if (was_down && !contact[s]) begin
            len = (ticks[s] < min_step) ? min_step : ticks[s];
            ring_sum[s] = ring_sum[s] - ring[s][slot[s]] + len;
            ring[s][slot[s]] = len;
            avg_step[s] = ring_sum[s] / HISTORY;
            ticks[s] = 0;
            slot[s] = (slot[s] + 1) % HISTORY;
        end else if (ticks[s] < timeout) begin
            if (avg_step[s] == 0) begin
                pct = (ticks[s] != 0) ? FULL : 0;
            end else begin
                pct = ticks[s] * FULL / avg_step[s];
                if (pct > FULL) pct = FULL;
            end
            ticks[s]++;
        end
        return pct;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_gait_sample        want;
        logic [STATUS_W-1:0] pressed;
        logic [ADC_W-1:0]    pad [NPAD];
        if (!i_rst_n) begin
            thresh    = THRESH_RST;
            debounce  = DEBOUNCE_RST;
            min_step  = MIN_STEP_RST;
            timeout   = TIMEOUT_RST;
            init_step = INIT_STEP_RST;
            for (int s = 0; s < NSIDE; s++) begin
                heel_prev[s] = 1'b0;
                contact[s]   = 1'b0;
                hold[s]      = 0;
                ticks[s]     = 0;
                avg_step[s]  = 0;
            end
            refill_rings();
            gait_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: thresh = i_cfg_data[ADC_W-1:0];
                    CFG_DEBOUNCE:  debounce = i_cfg_data[HOLD_W-1:0];
                    CFG_MIN_STEP:  min_step = i_cfg_data;
                    CFG_TIMEOUT:   timeout = i_cfg_data;
                    CFG_INIT_STEP: begin
                        init_step = i_cfg_data;
                        refill_rings();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pad = '{i_toe_left, i_heel_left, i_mid_a_left, i_mid_b_left,
                        i_toe_right, i_heel_right, i_mid_a_right, i_mid_b_right};
                for (int p = 0; p < NPAD; p++) pressed[p] = (pad[p] >= thresh);
                want.status        = pressed;
                want.percent_left  = PCT_W'(advance_side(SIDE_LEFT, pressed[HEEL_BIT_LEFT]));
                want.percent_right = PCT_W'(advance_side(SIDE_RIGHT, pressed[HEEL_BIT_RIGHT]));
                want.contact_left  = contact[SIDE_LEFT];
                want.contact_right = contact[SIDE_RIGHT];
                want.avg_left      = TICK_W'(avg_step[SIDE_LEFT]);
                want.avg_right     = TICK_W'(avg_step[SIDE_RIGHT]);
                gait_due.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                if (gait_due.size() == 0) begin
                    $error("result with no request pending, status %0h", i_sensor_status);
                    fails++;
                end else begin
                    want = gait_due.pop_front();
                    check_field("sensor_status", want.status, i_sensor_status);
                    check_field("contact_left", want.contact_left, i_contact_left);
                    check_field("contact_right", want.contact_right, i_contact_right);
                    check_field("percent_left", want.percent_left, i_percent_left);
                    check_field("percent_right", want.percent_right, i_percent_right);
                    check_field("avg_step_left", want.avg_left, i_avg_step_left);
                    check_field("avg_step_right", want.avg_right, i_avg_step_right);
                end
            end
        end
        o_pending = gait_due.size();
    end

endmodule

// ===== tb/testbench.sv =====
// gait phase estimator testbench top: clock, reset, register settings, pressure
// sample stimulus with random idling on both channels, and the final verdict
// depends on gpe_pkg, gait_phase_estimator, gpe_checker
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gpe_pkg::*;

    localparam int HISTORY_DEPTH = 3;
    localparam int HALF_PERIOD   = 4;
    localparam int NPAD          = 8;
    localparam int PADS_PER_SIDE = 4;
    localparam int HEEL_PAD      = 1;
    localparam int ADC_MAX       = (1 << ADC_W) - 1;
    localparam int GAP_PCT       = 25;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN         = 80;
    localparam int CYCLE_LIMIT   = 500000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [ADC_W-1:0]      i_toe_left = '0;
    logic [ADC_W-1:0]      i_heel_left = '0;
    logic [ADC_W-1:0]      i_mid_a_left = '0;
    logic [ADC_W-1:0]      i_mid_b_left = '0;
    logic [ADC_W-1:0]      i_toe_right = '0;
    logic [ADC_W-1:0]      i_heel_right = '0;
    logic [ADC_W-1:0]      i_mid_a_right = '0;
    logic [ADC_W-1:0]      i_mid_b_right = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [STATUS_W-1:0]   o_sensor_status;
    logic                  o_contact_left;
    logic                  o_contact_right;
    logic [PCT_W-1:0]      o_percent_left;
    logic [PCT_W-1:0]      o_percent_right;
    logic [TICK_W-1:0]     o_avg_step_left;
    logic [TICK_W-1:0]     o_avg_step_right;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int               fail_count;
    int               pending_count;
    int               cycle_count = 0;
    int               sent_count = 0;
    int               setting_count = 1;
    bit               idle_on = 1'b1;
    bit               long_hold_req = 1'b0;
    logic [ADC_W-1:0] thr_now = THRESH_RST;
    logic [ADC_W-1:0] pads [NPAD] = '{default: '0};
    bit               heel_down [NSIDE] = '{default: 1'b0};
    int               stance_rem [NSIDE] = '{default: 0};

    gait_phase_estimator #(.HISTORY(HISTORY_DEPTH)) dut (.*);

    gpe_checker #(.HISTORY(HISTORY_DEPTH)) gait_check (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .i_in_stall        (o_in_stall),
        .i_toe_left,
        .i_heel_left,
        .i_mid_a_left,
        .i_mid_b_left,
        .i_toe_right,
        .i_heel_right,
        .i_mid_a_right,
        .i_mid_b_right,
        .i_out_valid       (o_out_valid),
        .i_out_stall,
        .i_sensor_status   (o_sensor_status),
        .i_contact_left    (o_contact_left),
        .i_contact_right   (o_contact_right),
        .i_percent_left    (o_percent_left),
        .i_percent_right   (o_percent_right),
        .i_avg_step_left   (o_avg_step_left),
        .i_avg_step_right  (o_avg_step_right),
        .i_cfg_wr_en,
        .i_cfg_index,
        .i_cfg_data,
        .o_fail_count      (fail_count),
        .o_pending         (pending_count)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int hold_cycles;
        bit stall_now;
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                stall_now = 1'b1;
                hold_cycles = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_now = 1'b1;
                hold_cycles = $urandom_range(1, 14);
            end else begin
                stall_now = 1'b0;
                hold_cycles = idle_on ? $urandom_range(1, 20) : 1;
            end
            i_out_stall <= stall_now;
            repeat (hold_cycles) @(negedge i_clk);
        end
    end

    task automatic send_sample(input int gap_pct);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 14) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_toe_left    <= pads[0];
        i_heel_left   <= pads[1];
        i_mid_a_left  <= pads[2];
        i_mid_b_left  <= pads[3];
        i_toe_right   <= pads[4];
        i_heel_right  <= pads[5];
        i_mid_a_right <= pads[6];
        i_mid_b_right <= pads[7];
        i_in_valid    <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_flat(input logic [ADC_W-1:0] level);
        foreach (pads[p]) pads[p] = level;
        send_sample(GAP_PCT);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // drain the block, then load a full register set and hit the unused indexes
    task automatic configure(input logic [CFG_DATA_W-1:0] thr, deb, min_len, tmo, init_len);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_DEBOUNCE, deb);
        write_reg(CFG_MIN_STEP, min_len);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_INIT_STEP, init_len);
        for (int idx = CFG_INIT_STEP + 1; idx < 2 ** CFG_IDX_W; idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        thr_now = thr[ADC_W-1:0];
        setting_count++;
    endtask

    // alternating heel stance and swing per side, with optional single-tick bounce
    task automatic run_gait(input int n, input int on_lo, on_hi, off_lo, off_hi,
                            input int bounce_pct);
        bit pressed;
        for (int k = 0; k < n; k++) begin
            foreach (pads[p]) pads[p] = ADC_W'($urandom_range(0, ADC_MAX));
            for (int s = 0; s < NSIDE; s++) begin
                if (stance_rem[s] == 0) begin
                    heel_down[s] = !heel_down[s];
                    stance_rem[s] = heel_down[s] ? $urandom_range(on_lo, on_hi)
                                                 : $urandom_range(off_lo, off_hi);
                end
                stance_rem[s]--;
                pressed = heel_down[s] ^ ($urandom_range(0, 99) < bounce_pct);
                if (pressed)
                    pads[PADS_PER_SIDE*s + HEEL_PAD] = ADC_W'($urandom_range(thr_now, ADC_MAX));
                else if (thr_now == 0)
                    pads[PADS_PER_SIDE*s + HEEL_PAD] = '0;
                else
                    pads[PADS_PER_SIDE*s + HEEL_PAD] = ADC_W'($urandom_range(0, thr_now - 1));
            end
            send_sample(GAP_PCT);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_flat('0);
        send_flat(ADC_W'(ADC_MAX));
        send_flat(ADC_W'(THRESH_RST - 1));
        send_flat(THRESH_RST);
        for (int w = 0; w < NPAD; w++) begin
            foreach (pads[p]) pads[p] = (p == w) ? ADC_W'(ADC_MAX) : '0;
            send_sample(GAP_PCT);
        end
        foreach (pads[p]) pads[p] = (p % 2 == 0) ? THRESH_RST : ADC_W'(THRESH_RST - 1);
        send_sample(GAP_PCT);
        foreach (pads[p]) pads[p] = (p % 2 == 0) ? ADC_W'(THRESH_RST - 1) : THRESH_RST;
        send_sample(GAP_PCT);

        configure(12'd300, 12'hF00, 12'd1, 12'd30, 12'd4);
        long_hold_req = 1'b1;
        run_gait(140, 3, 12, 3, 12, 5);

        configure(12'hFFF, 12'd2, 12'd12, 12'd4095, 12'd4095);
        idle_on = 1'b0;
        run_gait(70, 4, 20, 4, 20, 5);

        configure(12'd0, 12'd255, 12'd4095, 12'd1, 12'd1);
        idle_on = 1'b1;
        run_gait(40, 1, 4, 1, 4, 10);

        // zero clamp and zero timeout leave zero-length steps and a zero average
        configure(12'd700, 12'd5, 12'd0, 12'd0, 12'd0);
        run_gait(60, 6, 12, 6, 12, 5);

        configure(12'd512, 12'd1, 12'd3, 12'd25, 12'd8);
        run_gait(130, 2, 15, 2, 15, 8);
        run_gait(30, 1, 2, 1, 2, 30);

        // long stance lets the hold count reach saturation
        configure(12'd512, 12'd254, 12'd40, 12'd600, 12'd200);
        run_gait(180, 262, 262, 5, 20, 0);
        idle_on = 1'b0;
        run_gait(100, 262, 262, 5, 20, 0);

        i_in_valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);

        $display("gait estimator: %0d pressure samples over %0d register settings,",
                 sent_count, setting_count);
        $display("  with a long result hold-off and random idling on both channels");
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/gpe_pkg.sv
sv/gpe_div.sv
sv/gpe_datapath.sv
sv/gpe_ctrl.sv
sv/gait_phase_estimator.sv
tb/gpe_checker.sv
tb/testbench.sv
